// ----- rtl/core/ncm_pkg.sv -----
// Package for the nearest centroid color map: field widths, item structs and
// the token that walks the centroid cell chain, plus its compare function.
// No dependencies.
`default_nettype none

package ncm_pkg;

    localparam int IDX_W       = 4;
    localparam int PIX_W       = 8;
    localparam int MEAN_W      = 16;
    localparam int SQ_W        = 2 * MEAN_W;
    localparam int DIST_W      = SQ_W + 2;
    localparam int CNT_W       = 5;
    localparam int ENTRIES_DEF = 16;
    localparam int INDEX_SPAN  = 16;

    localparam logic [CNT_W-1:0] ENTRIES_IN_USE_RST = CNT_W'(16);

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [IDX_W-1:0]  entry_index;
        logic [PIX_W-1:0]  pixel_red;
        logic [PIX_W-1:0]  pixel_green;
        logic [PIX_W-1:0]  pixel_blue;
        logic [MEAN_W-1:0] mean_red;
        logic [MEAN_W-1:0] mean_green;
        logic [MEAN_W-1:0] mean_blue;
    } ncm_in_t;

    typedef struct packed {
        logic             is_classify;
        logic [IDX_W-1:0] cluster_index;
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
    } ncm_out_t;

    typedef struct packed {
        logic [MEAN_W-1:0] red;
        logic [MEAN_W-1:0] green;
        logic [MEAN_W-1:0] blue;
    } ncm_entry_t;

    typedef struct packed {
        logic              valid;
        logic [PIX_W-1:0]  pix_r;
        logic [PIX_W-1:0]  pix_g;
        logic [PIX_W-1:0]  pix_b;
        logic              have;
        logic [IDX_W-1:0]  best_idx;
        logic [DIST_W-1:0] best_d;
        logic [PIX_W-1:0]  best_r;
        logic [PIX_W-1:0]  best_g;
        logic [PIX_W-1:0]  best_b;
        logic              cand;
        logic [IDX_W-1:0]  cand_idx;
        logic [SQ_W-1:0]   sq_r;
        logic [SQ_W-1:0]   sq_g;
        logic [SQ_W-1:0]   sq_b;
        logic [PIX_W-1:0]  cand_r;
        logic [PIX_W-1:0]  cand_g;
        logic [PIX_W-1:0]  cand_b;
    } ncm_token_t;

    // Sums the pending candidate's squares and keeps it if it is the first or strictly closer.
    function automatic ncm_token_t ncm_fold(ncm_token_t t);
        ncm_token_t        r;
        logic [DIST_W-1:0] d;
        r = t;
        d = DIST_W'(t.sq_r) + DIST_W'(t.sq_g) + DIST_W'(t.sq_b);
        if (t.cand && (!t.have || d < t.best_d))
        begin
            r.have     = 1'b1;
            r.best_idx = t.cand_idx;
            r.best_d   = d;
            r.best_r   = t.cand_r;
            r.best_g   = t.cand_g;
            r.best_b   = t.cand_b;
        end
        r.cand = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ncm_cell.sv -----
// One cell of the centroid chain: holds one table entry, folds the previous
// cell's candidate into the running best and squares its own distances.
// Depends on ncm_pkg.
`default_nettype none

module ncm_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire ncm_pkg::ncm_entry_t         wr_data,
    input  wire logic [ncm_pkg::CNT_W-1:0]   n_eff,
    input  wire ncm_pkg::ncm_token_t         tok_in,
    output ncm_pkg::ncm_token_t              tok_out
);
    import ncm_pkg::*;

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    ncm_entry_t entry_reg;
    ncm_entry_t entry_next;
    ncm_token_t tok_reg;
    ncm_token_t tok_next;

    function automatic logic [SQ_W-1:0] chan_sq(logic [PIX_W-1:0] pix,
                                                logic [MEAN_W-1:0] mean);
        logic [MEAN_W-1:0] p;
        logic [MEAN_W-1:0] diff;
        p    = {pix, {(MEAN_W - PIX_W){1'b0}}};
        diff = (p > mean) ? (p - mean) : (mean - p);
        return SQ_W'(diff) * SQ_W'(diff);
    endfunction

    always_comb
    begin
        entry_next = wr_en ? wr_data : entry_reg;
        tok_next          = ncm_fold(tok_in);
        tok_next.cand     = tok_in.valid && (MY_CNT < n_eff);
        tok_next.cand_idx = MY_IDX;
        tok_next.sq_r     = chan_sq(tok_in.pix_r, entry_reg.red);
        tok_next.sq_g     = chan_sq(tok_in.pix_g, entry_reg.green);
        tok_next.sq_b     = chan_sq(tok_in.pix_b, entry_reg.blue);
        tok_next.cand_r   = entry_reg.red[MEAN_W-1 -: PIX_W];
        tok_next.cand_g   = entry_reg.green[MEAN_W-1 -: PIX_W];
        tok_next.cand_b   = entry_reg.blue[MEAN_W-1 -: PIX_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ----- rtl/core/nearest_centroid_color_map.sv -----
// A load item writes one centroid entry and its acknowledgement appears on
// the cycle after it is accepted. A classify item walks a chain of one cell
// per table entry (min(ENTRIES, 16) cells), one cell per clock, and a final
// fold into the result register picks the winner; busy is high meanwhile.
// done marks each result for one cycle and the receiver cannot stall it.
// Depends on ncm_pkg and ncm_cell.
`default_nettype none

module nearest_centroid_color_map #(
    parameter int ENTRIES = ncm_pkg::ENTRIES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire ncm_pkg::ncm_in_t            cmd,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ncm_pkg::CNT_W-1:0]   cfg_wr_data,
    output logic                             done,
    output ncm_pkg::ncm_out_t                result
);
    import ncm_pkg::*;

    localparam int CHAIN = (ENTRIES < INDEX_SPAN) ? ENTRIES : INDEX_SPAN;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CHAIN);

    logic [CNT_W-1:0] in_use_reg;
    logic [CNT_W-1:0] in_use_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    ncm_out_t         result_reg;
    ncm_out_t         result_next;

    logic             accept;
    logic [CNT_W-1:0] n_eff;
    ncm_entry_t       wr_data;
    ncm_token_t       tok [CHAIN+1];
    ncm_token_t       fin;
    logic [CHAIN-1:0] tok_valid;

    assign accept = start && !busy_reg;

    always_comb
    begin
        if (in_use_reg == '0)
            n_eff = CNT_W'(1);
        else if (in_use_reg > CAP)
            n_eff = CAP;
        else
            n_eff = in_use_reg;
    end

    assign wr_data.red   = cmd.mean_red;
    assign wr_data.green = cmd.mean_green;
    assign wr_data.blue  = cmd.mean_blue;

    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = accept && (cmd.opcode == OP_CLASSIFY);
        tok[0].pix_r = cmd.pixel_red;
        tok[0].pix_g = cmd.pixel_green;
        tok[0].pix_b = cmd.pixel_blue;
    end

    for (genvar i = 0; i < CHAIN; i++)
    begin : g_cell
        ncm_cell #(
            .INDEX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .wr_en  (accept && (cmd.opcode == OP_LOAD) &&
                     (cmd.entry_index == IDX_W'(i))),
            .wr_data(wr_data),
            .n_eff  (n_eff),
            .tok_in (tok[i]),
            .tok_out(tok[i+1])
        );
        assign tok_valid[i] = tok[i+1].valid;
    end

    assign fin = ncm_fold(tok[CHAIN]);

    always_comb
    begin
        in_use_next = cfg_wr_en ? cfg_wr_data : in_use_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (tok[CHAIN].valid)
        begin
            busy_next                 = 1'b0;
            done_next                 = 1'b1;
            result_next.is_classify   = 1'b1;
            result_next.cluster_index = fin.best_idx;
            result_next.out_red       = fin.best_r;
            result_next.out_green     = fin.best_g;
            result_next.out_blue      = fin.best_b;
        end
        else if (accept && (cmd.opcode == OP_LOAD))
        begin
            done_next                 = 1'b1;
            result_next.is_classify   = 1'b0;
            result_next.cluster_index = cmd.entry_index;
            result_next.out_red       = cmd.mean_red[MEAN_W-1 -: PIX_W];
            result_next.out_green     = cmd.mean_green[MEAN_W-1 -: PIX_W];
            result_next.out_blue      = cmd.mean_blue[MEAN_W-1 -: PIX_W];
        end
        else if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= ENTRIES_IN_USE_RST;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // At most one classify item is ever inside the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid))
        else $error("more than one item in the centroid chain");

    // A token in the chain always keeps the block busy.
    a_busy_token: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid != '0) |-> busy_reg)
        else $error("item in flight while not busy");

    // A result is never shown while a classify item is still in flight.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result shown while busy");

    // A load is acknowledged on the next cycle.
    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.opcode == OP_LOAD)) |=> (done_reg && !result_reg.is_classify))
        else $error("load item not acknowledged");

    // A classify item raises busy on the next cycle.
    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.opcode == OP_CLASSIFY)) |=> (busy_reg && !done_reg))
        else $error("classify item did not start");

endmodule

`default_nettype wire
